@@ rtl/core/lsd_rs_pkg.sv @@
// Shared types and constants for the LSD radix sort block.
package lsd_rs_pkg;

  localparam int unsigned ValueWidth = 32;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_COUNT,
    ST_PREFIX,
    ST_SCATTER,
    ST_COPY,
    ST_EMIT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_wr;      // store an incoming value
    logic clr_counts;   // clear the buckets and the digit-left flag
    logic count_step;   // count the digit of the entry at idx
    logic prefix_step;  // turn bucket bidx into its start position
    logic scatter_step; // place the entry at idx into the target store
    logic copy_step;    // copy target entry idx back to the source store
    logic next_digit;   // advance to the next digit
    logic reset_digit;  // restart at the lowest digit
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic go_on;        // some value has digits above the current one
    logic last_digit;   // current digit is the top one
  } dp_stat_t;

endpackage

@@ rtl/core/lsd_rs_ctrl.sv @@
// Controller state machine for the LSD radix sort block.
module lsd_rs_ctrl #(
  parameter int MAX_ITEMS  = 64,
  parameter int DIGIT_BITS = 4
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_fire,
  input  logic                in_last,
  input  logic                out_fire,
  input  lsd_rs_pkg::dp_stat_t stat,
  output lsd_rs_pkg::dp_cmd_t  cmd,
  output logic [$clog2(MAX_ITEMS+1)-1:0] count,
  output logic [$clog2(MAX_ITEMS)-1:0]   idx,
  output logic [DIGIT_BITS-1:0]          bidx,
  output logic                in_ready,
  output logic                emit_valid,
  output logic                emit_last,
  output logic                ovf
);
  import lsd_rs_pkg::*;

  localparam int CW = $clog2(MAX_ITEMS + 1);
  localparam int IW = $clog2(MAX_ITEMS);
  localparam int NB = 1 << DIGIT_BITS;

  state_t state, state_next;
  logic [CW-1:0] pos;   // walk counter over the stored entries
  logic          idx_last;
  logic          bkt_last;
  logic          pos_wait; // marks a registered read in flight
  // In the walk states rd_done alternates per entry: while it is low the stores
  // are addressed, while it is high the registered read data is acted on.
  logic          rd_done;

  assign idx      = pos[IW-1:0];
  assign idx_last = (pos + CW'(1) == count);
  assign bkt_last = (bidx == DIGIT_BITS'(NB - 1));

  always_comb begin
    state_next = state;
    case (state)
      ST_LOAD: if (in_fire && in_last) state_next = ST_COUNT;
      ST_COUNT: if (rd_done && idx_last) state_next = ST_PREFIX;
      ST_PREFIX: if (bkt_last) state_next = ST_SCATTER;
      ST_SCATTER: if (rd_done && idx_last) state_next = ST_COPY;
      ST_COPY: begin
        if (rd_done && idx_last) begin
          if (stat.go_on && !stat.last_digit) state_next = ST_COUNT;
          else state_next = ST_EMIT;
        end
      end
      ST_EMIT: if (out_fire && emit_last) state_next = ST_LOAD;
      default: state_next = ST_LOAD;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_ready = 1'b0;
    case (state)
      ST_LOAD: begin
        in_ready = 1'b1;
        cmd.load_wr = in_fire && (count != CW'(MAX_ITEMS));
        cmd.clr_counts = 1'b1;
        cmd.reset_digit = 1'b1;
      end
      ST_COUNT: cmd.count_step = rd_done;
      ST_PREFIX: cmd.prefix_step = 1'b1;
      ST_SCATTER: cmd.scatter_step = rd_done;
      ST_COPY: begin
        cmd.copy_step = rd_done;
        if (rd_done && idx_last) begin
          cmd.next_digit = 1'b1;
          cmd.clr_counts = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // In ST_EMIT, pos counts down from the top entry; the source store
  // read is registered, so pos_wait marks a fresh read in flight.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
      pos <= '0;
      count <= '0;
      bidx <= '0;
      ovf <= 1'b0;
      emit_valid <= 1'b0;
      emit_last <= 1'b0;
      pos_wait <= 1'b0;
      rd_done <= 1'b0;
    end else begin
      state <= state_next;
      case (state)
        ST_LOAD: begin
          pos <= '0;
          bidx <= '0;
          if (in_fire) begin
            if (count != CW'(MAX_ITEMS)) count <= count + CW'(1);
            else ovf <= 1'b1;
            if (in_last && count == '0 && count != CW'(MAX_ITEMS)) begin
              pos <= '0;
            end
          end
        end
        ST_COUNT, ST_SCATTER: begin
          rd_done <= !rd_done;
          if (rd_done) pos <= idx_last ? '0 : pos + CW'(1);
        end
        ST_PREFIX: bidx <= bidx + DIGIT_BITS'(1);
        ST_COPY: begin
          rd_done <= !rd_done;
          if (rd_done) begin
            pos <= idx_last ? ((state_next == ST_EMIT) ? count - CW'(1) : '0)
                            : pos + CW'(1);
            pos_wait <= idx_last && state_next == ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (pos_wait) begin
            emit_valid <= 1'b1;
            emit_last <= (pos == '0);
            pos_wait <= 1'b0;
          end else if (out_fire) begin
            if (emit_last) begin
              emit_valid <= 1'b0;
              emit_last <= 1'b0;
              count <= '0;
              ovf <= 1'b0;
            end else begin
              emit_valid <= 1'b0;
              pos <= pos - CW'(1);
              pos_wait <= 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  property p_ready_only_load;
    @(posedge clk) disable iff (rst) in_ready |-> state == ST_LOAD;
  endproperty
  a_ready_only_load: assert property (p_ready_only_load) else $error("ready outside load");

  property p_count_bound;
    @(posedge clk) disable iff (rst) count <= CW'(MAX_ITEMS);
  endproperty
  a_count_bound: assert property (p_count_bound) else $error("count overrun");

  property p_emit_clears;
    @(posedge clk) disable iff (rst) (out_fire && emit_last) |=> count == '0 && !ovf;
  endproperty
  a_emit_clears: assert property (p_emit_clears) else $error("batch not cleared");
endmodule

@@ rtl/core/lsd_rs_dp.sv @@
// Datapath for the LSD radix sort block: stores, bucket counters, digit select.
module lsd_rs_dp #(
  parameter int MAX_ITEMS  = 64,
  parameter int DIGIT_BITS = 4
) (
  input  logic                clk,
  input  logic                rst,
  input  lsd_rs_pkg::dp_cmd_t  cmd,
  input  logic [$clog2(MAX_ITEMS+1)-1:0] count,
  input  logic [$clog2(MAX_ITEMS)-1:0]   idx,
  input  logic [DIGIT_BITS-1:0]          bidx,
  input  logic [31:0]         in_value,
  output lsd_rs_pkg::dp_stat_t stat,
  output logic [31:0]         rd_value
);
  import lsd_rs_pkg::*;

  localparam int CW = $clog2(MAX_ITEMS + 1);
  localparam int IW = $clog2(MAX_ITEMS);
  localparam int NB = 1 << DIGIT_BITS;
  localparam int NP = (ValueWidth + DIGIT_BITS - 1) / DIGIT_BITS;
  localparam int PW = $clog2(NP + 1);

  logic [31:0] src_mem [MAX_ITEMS];
  logic [31:0] tgt_mem [MAX_ITEMS];
  logic [CW-1:0] bucket [NB];
  logic [CW-1:0] run_sum;
  logic [PW-1:0] pass;
  logic [5:0]    shift;
  logic          go_on;
  logic [31:0]   src_rd;
  logic [31:0]   tgt_rd;
  logic [31:0]   cur;
  logic [DIGIT_BITS-1:0] dig;
  logic [5:0]    next_shift;
  logic [IW-1:0] src_addr;

  assign shift = 6'(pass * DIGIT_BITS);
  assign next_shift = shift + 6'(DIGIT_BITS);
  // Both stores are read through registers at idx; the walk acts on the
  // registered data in the cycle after the address is set.
  assign src_addr = idx;
  assign cur = src_rd;
  assign dig = DIGIT_BITS'(cur >> shift);
  assign stat.go_on = go_on;
  assign stat.last_digit = (next_shift >= 6'(ValueWidth));

  always_ff @(posedge clk) begin
    if (cmd.load_wr) src_mem[count[IW-1:0]] <= in_value;
    else if (cmd.copy_step) src_mem[idx] <= tgt_rd;
    if (cmd.scatter_step) tgt_mem[bucket[dig][IW-1:0]] <= cur;
    src_rd <= src_mem[src_addr];
    tgt_rd <= tgt_mem[idx];
  end
  assign rd_value = src_rd;

  always_ff @(posedge clk) begin
    if (rst) begin
      pass <= '0;
      go_on <= 1'b0;
      run_sum <= '0;
      for (int i = 0; i < NB; i++) bucket[i] <= '0;
    end else begin
      if (cmd.reset_digit) pass <= '0;
      else if (cmd.next_digit) pass <= pass + PW'(1);
      if (cmd.clr_counts) begin
        go_on <= 1'b0;
        run_sum <= '0;
        for (int i = 0; i < NB; i++) bucket[i] <= '0;
      end else if (cmd.count_step) begin
        bucket[dig] <= bucket[dig] + CW'(1);
        if (next_shift < 6'(ValueWidth) && (cur >> next_shift) != 32'd0) go_on <= 1'b1;
      end else if (cmd.prefix_step) begin
        bucket[bidx] <= run_sum;
        run_sum <= run_sum + bucket[bidx];
      end else if (cmd.scatter_step) begin
        bucket[dig] <= bucket[dig] + CW'(1);
      end
    end
  end

  property p_prefix_total;
    @(posedge clk) disable iff (rst) cmd.scatter_step |-> run_sum == count;
  endproperty
  a_prefix_total: assert property (p_prefix_total) else $error("bucket total mismatch");

  property p_pass_range;
    @(posedge clk) disable iff (rst) pass <= PW'(NP);
  endproperty
  a_pass_range: assert property (p_pass_range) else $error("pass overrun");

  property p_one_op;
    @(posedge clk) disable iff (rst)
      $onehot0({cmd.count_step, cmd.prefix_step, cmd.scatter_step, cmd.copy_step});
  endproperty
  a_one_op: assert property (p_one_op) else $error("conflicting commands");
endmodule

@@ rtl/core/lsd_radix_sort_descending_top.sv @@
// Top level of the LSD radix sort block (descending output).
// Loading accepts one value per cycle. Each digit pass then counts the digits
// of the stored values, turns the buckets into start positions, scatters the
// values into the target store and copies them back; passes end once no value
// has higher digits left, at most ceil(32/DIGIT_BITS). Emitting runs from the top
// entry down through the registered store read. Reset (rst, synchronous) empties the batch.
module lsd_radix_sort_descending_top #(
  parameter int MAX_ITEMS  = 64,
  parameter int DIGIT_BITS = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // value[31:0]
  input  logic        s_tlast,   // last
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // sorted_value[31:0]
  output logic        m_tlast,   // end_of_batch
  output logic        m_tuser    // overflow
);
  import lsd_rs_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;
  logic [$clog2(MAX_ITEMS+1)-1:0] count;
  logic [$clog2(MAX_ITEMS)-1:0]   idx;
  logic [DIGIT_BITS-1:0]          bidx;
  logic in_fire, out_fire;

  assign in_fire  = s_tvalid && s_tready;
  assign out_fire = m_tvalid && m_tready;

  lsd_rs_ctrl #(.MAX_ITEMS(MAX_ITEMS), .DIGIT_BITS(DIGIT_BITS)) u_ctrl (
    .clk, .rst, .in_fire, .in_last(s_tlast), .out_fire, .stat, .cmd,
    .count, .idx, .bidx, .in_ready(s_tready), .emit_valid(m_tvalid),
    .emit_last(m_tlast), .ovf(m_tuser)
  );

  lsd_rs_dp #(.MAX_ITEMS(MAX_ITEMS), .DIGIT_BITS(DIGIT_BITS)) u_dp (
    .clk, .rst, .cmd, .count, .idx, .bidx, .in_value(s_tdata), .stat,
    .rd_value(m_tdata)
  );
endmodule

@@ verif/tb_lsd_radix_sort_descending_top.sv @@
// Testbench for the radix sort block: directed and random batches checked against a sorting predictor.
`timescale 1ns / 1ps

class sort_scoreboard;
  bit [31:0] batch_values[$];
  bit        batch_dropped;
  bit [31:0] want_value[$];
  bit        want_end[$];
  bit        want_ovf[$];
  int        errors;

  function new();
    errors = 0;
    batch_dropped = 0;
  endfunction

  // Predicts the whole batch once the last item has been accepted.
  function void note_input(bit [31:0] value, bit last);
    bit [31:0] sorted[$];
    if (batch_values.size() < 64) begin
      batch_values.push_back(value);
    end else begin
      batch_dropped = 1;
    end
    if (last) begin
      sorted = batch_values;
      sorted.rsort();
      foreach (sorted[k]) begin
        want_value.push_back(sorted[k]);
        want_end.push_back(k == sorted.size() - 1);
        want_ovf.push_back(batch_dropped);
      end
      batch_values.delete();
      batch_dropped = 0;
    end
  endfunction

  function void check_result(bit [31:0] value, bit end_flag, bit ovf);
    bit [31:0] ev;
    bit        ee;
    bit        eo;
    if (want_value.size() == 0) begin
      $error("unexpected sorted_value %h", value);
      errors++;
      return;
    end
    ev = want_value.pop_front();
    ee = want_end.pop_front();
    eo = want_ovf.pop_front();
    if (ev != value) begin
      $error("sorted_value expected %h actual %h", ev, value);
      errors++;
    end
    if (ee != end_flag) begin
      $error("end_of_batch expected %0d actual %0d", ee, end_flag);
      errors++;
    end
    if (eo != ovf) begin
      $error("overflow expected %0d actual %0d", eo, ovf);
      errors++;
    end
  endfunction
endclass

module tb_lsd_radix_sort_descending_top;
  logic        clk = 0;
  logic        rst = 1;
  logic        s_tvalid = 0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;
  logic        s_tlast = 0;
  logic        m_tvalid;
  logic        m_tready = 0;
  logic [31:0] m_tdata;
  logic        m_tlast;
  logic        m_tuser;

  sort_scoreboard board = new();
  longint cycles = 0;
  bit     stall_free = 0;

  lsd_radix_sort_descending_top dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .m_tuser(m_tuser)
  );

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  function automatic int gap_len();
    if (stall_free) return 0;
    if ($urandom_range(9) < 6) return 0;
    if ($urandom_range(9) < 8) return $urandom_range(3, 1);
    return $urandom_range(40, 5);
  endfunction

  // Valid drops only when a gap follows, so a back-to-back transaction
  // never sees two assignments to s_tvalid in one time step.
  task automatic send_item(bit [31:0] value, bit last);
    int g;
    g = gap_len();
    if (g > 0) begin
      s_tvalid <= 0;
      repeat (g) @(posedge clk);
    end
    s_tvalid <= 1;
    s_tdata  <= value;
    s_tlast  <= last;
    do @(posedge clk); while (!s_tready);
    board.note_input(value, last);
  endtask

  function automatic bit [31:0] rand_value();
    case ($urandom_range(4))
      0: return $urandom_range(15);
      1: return $urandom_range(4095);
      2: return 32'hffff_fff0 | $urandom_range(15);
      default: return $urandom();
    endcase
  endfunction

  task automatic send_batch(int n, bit small_vals);
    for (int i = 0; i < n; i++)
      send_item(small_vals ? $urandom_range(7) : rand_value(), i == n - 1);
  endtask

  // Sink with random back-pressure; results are sampled at the edge.
  always @(posedge clk) begin
    cycles++;
    if (!rst) begin
      if (m_tvalid && m_tready) board.check_result(m_tdata, m_tlast, m_tuser);
      m_tready <= (stall_free || $urandom_range(9) < 7);
    end
    if (cycles > 2000000) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // Directed: single item, extremes, equal values, full batch with overflow.
    send_item(32'h0, 1);
    send_item(32'hffff_ffff, 1);
    send_item(32'h0, 0);
    send_item(32'hffff_ffff, 0);
    send_item(32'h8000_0001, 0);
    send_item(32'h5555_5555, 0);
    send_item(32'haaaa_aaaa, 1);
    send_item(32'd7, 0);
    send_item(32'd7, 0);
    send_item(32'd3, 1);
    stall_free = 1;
    for (int i = 0; i < 66; i++) send_item(rand_value(), i == 65);
    stall_free = 0;
    s_tvalid <= 0;
    // Hold off until every result of the overflow batch has drained.
    while (board.want_value.size() != 0) @(posedge clk);
    // Random batches, mostly small.
    for (int b = 0; b < 5; b++) begin
      send_batch($urandom_range(8, 1), $urandom_range(3) == 0);
    end
    s_tvalid <= 0;
    while (board.want_value.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (board.errors == 0 && board.want_value.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule

@@ lsd_radix_sort_descending_top.f @@
rtl/core/lsd_rs_pkg.sv
rtl/core/lsd_rs_ctrl.sv
rtl/core/lsd_rs_dp.sv
rtl/core/lsd_radix_sort_descending_top.sv
verif/tb_lsd_radix_sort_descending_top.sv
